/* design/vtdi_pkg.sv */
package vtdi_pkg;

    // Width of each incoming source index field.
    localparam int IN_BITS = 16;

    // Number of source index fields in one tuple.
    localparam int FIELD_COUNT = 5;

    // Width of the reported vertex index.
    localparam int OUT_BITS = 10;

    // Occupancy flags that the tuple queue reports to both of its sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // States of the search engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH
    } t_back_state;

endpackage

/* design/vtdi_front.sv */
module vtdi_front
    import vtdi_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic                                  i_start,
    input  logic signed [IN_BITS-1:0]             i_position_index,
    input  logic signed [IN_BITS-1:0]             i_normal_index,
    input  logic signed [IN_BITS-1:0]             i_texcoord_index,
    input  logic signed [IN_BITS-1:0]             i_tangent_index,
    input  logic signed [IN_BITS-1:0]             i_binormal_index,
    input  logic                                  i_last_in_mesh,
    input  t_q_status                             i_q_status,
    output logic                                  o_busy,
    output logic                                  o_push,
    output logic [FIELD_COUNT*INDEX_BITS:0]       o_push_data
);

    localparam int EXT_BITS = 2 * IN_BITS;

    logic [EXT_BITS-1:0] ext_position;
    logic [EXT_BITS-1:0] ext_normal;
    logic [EXT_BITS-1:0] ext_texcoord;
    logic [EXT_BITS-1:0] ext_tangent;
    logic [EXT_BITS-1:0] ext_binormal;

    // Sign extend every field, then keep the low INDEX_BITS bits of it.
    assign ext_position = EXT_BITS'(i_position_index);
    assign ext_normal   = EXT_BITS'(i_normal_index);
    assign ext_texcoord = EXT_BITS'(i_texcoord_index);
    assign ext_tangent  = EXT_BITS'(i_tangent_index);
    assign ext_binormal = EXT_BITS'(i_binormal_index);

    // A beat is taken whenever the queue has room for it.
    assign o_busy = i_q_status.full;
    assign o_push = i_start && !i_q_status.full;

    // Pack the narrowed tuple with the end-of-mesh flag in the lowest bit.
    assign o_push_data = {ext_position[INDEX_BITS-1:0],
                          ext_normal[INDEX_BITS-1:0],
                          ext_texcoord[INDEX_BITS-1:0],
                          ext_tangent[INDEX_BITS-1:0],
                          ext_binormal[INDEX_BITS-1:0],
                          i_last_in_mesh};

endmodule

/* design/vtdi_queue.sv */
module vtdi_queue
    import vtdi_pkg::*;
#(
    parameter int DATA_BITS = 81
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_push_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_head_data,
    output t_q_status            o_status
);

    logic [DATA_BITS-1:0] r_slot [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_fill;
    logic                 n_wr_ptr;
    logic                 n_rd_ptr;
    logic [1:0]           n_fill;
    logic                 do_push;
    logic                 do_pop;

    // Guard both sides so that a stray request cannot corrupt the pointers.
    assign do_push = i_push && (r_fill != 2'd2);
    assign do_pop  = i_pop && (r_fill != 2'd0);

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (do_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Storage for the two queued beats.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head_data     = r_slot[r_rd_ptr];
    assign o_status.full   = (r_fill == 2'd2);
    assign o_status.empty  = (r_fill == 2'd0);

    // The fill count never goes past the number of slots.
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("queue fill count out of range");

endmodule

/* design/vtdi_back.sv */
module vtdi_back
    import vtdi_pkg::*;
#(
    parameter int MAX_UNIQUE = 1024,
    parameter int INDEX_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_q_status                             i_q_status,
    input  logic [FIELD_COUNT*INDEX_BITS:0]       i_head_data,
    output logic                                  o_pop,
    output logic                                  o_valid,
    output logic [OUT_BITS-1:0]                   o_vertex_index,
    output logic                                  o_is_new,
    output logic                                  o_overflow
);

    localparam int TUPLE_BITS = FIELD_COUNT * INDEX_BITS;
    localparam int AW         = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int CW         = $clog2(MAX_UNIQUE + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_UNIQUE);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_UNIQUE - 1);

    // Tuple table.
    logic [TUPLE_BITS-1:0] r_table [MAX_UNIQUE];
    logic [TUPLE_BITS-1:0] r_rd_data;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic                  mem_re;
    logic [AW-1:0]         mem_ra;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_issue;
    logic [CW-1:0]         n_issue;
    logic                  r_cmp_valid;
    logic                  n_cmp_valid;
    logic [AW-1:0]         r_cmp_addr;
    logic [AW-1:0]         n_cmp_addr;
    logic [TUPLE_BITS-1:0] r_tuple;
    logic [TUPLE_BITS-1:0] n_tuple;
    logic                  r_last;
    logic                  n_last;
    logic                  r_valid;
    logic                  n_valid;
    logic [AW-1:0]         r_index;
    logic [AW-1:0]         n_index;
    logic                  r_is_new;
    logic                  n_is_new;
    logic                  r_overflow;
    logic                  n_overflow;
    logic                  hit;
    logic                  finish;
    logic [AW+OUT_BITS-1:0] index_ext;

    // The entry read in the previous cycle is compared against the held tuple.
    assign hit = r_cmp_valid && (r_rd_data == r_tuple);

    // Search sequencer: one table read issued per cycle, each entry compared in the cycle after its read.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_cmp_valid = 1'b0;
        n_cmp_addr  = r_cmp_addr;
        n_tuple     = r_tuple;
        n_last      = r_last;
        n_valid     = 1'b0;
        n_index     = r_index;
        n_is_new    = r_is_new;
        n_overflow  = r_overflow;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_re      = 1'b0;
        mem_ra      = r_issue[AW-1:0];
        finish      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_tuple = i_head_data[TUPLE_BITS:1];
                    n_last  = i_head_data[0];
                    n_issue = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    // An earlier entry holds the same tuple.
                    finish     = 1'b1;
                    n_index    = r_cmp_addr;
                    n_is_new   = 1'b0;
                    n_overflow = 1'b0;
                end else if (r_issue != r_count) begin
                    mem_re      = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_addr  = r_issue[AW-1:0];
                    n_issue     = r_issue + CW'(1);
                end else begin
                    // Every stored entry has been compared without a match.
                    finish = 1'b1;
                    if (r_count < COUNT_FULL) begin
                        mem_we     = 1'b1;
                        n_index    = r_count[AW-1:0];
                        n_is_new   = 1'b1;
                        n_overflow = 1'b0;
                        n_count    = r_count + CW'(1);
                    end else begin
                        n_index    = LAST_ENTRY;
                        n_is_new   = 1'b0;
                        n_overflow = 1'b1;
                    end
                end
                if (finish) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_valid     <= n_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_cmp_addr <= n_cmp_addr;
        r_tuple    <= n_tuple;
        r_last     <= n_last;
        r_index    <= n_index;
        r_is_new   <= n_is_new;
        r_overflow <= n_overflow;
    end

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= r_tuple;
        end
        if (mem_re) begin
            r_rd_data <= r_table[mem_ra];
        end
    end

    // The reported index is the low bits of the entry number.
    assign index_ext      = {{OUT_BITS{1'b0}}, r_index};
    assign o_vertex_index = index_ext[OUT_BITS-1:0];
    assign o_valid        = r_valid;
    assign o_is_new       = r_is_new;
    assign o_overflow     = r_overflow;

    // Each result beat lasts exactly one cycle.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    // The stored tuple count stays within the table.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("tuple count beyond table depth");

    // An overflowing tuple is never reported as newly stored.
    a_overflow_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_overflow |-> !r_is_new)
        else $error("overflow reported together with a new entry");

    // A tuple is only stored while the table has room.
    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_count < COUNT_FULL)
        else $error("table write with no free entry");

endmodule

/* design/vertex_tuple_dedup_indexer_top.sv */
// Vertex tuple deduplication indexer.
//
// Input channel: a beat of five signed source indices and an end-of-mesh flag
// is taken at a rising edge where start is high and busy is low. A small
// two-beat queue sits behind the input, so busy only rises when that queue
// is full while the search engine works on an earlier tuple.
// Result channel: o_valid is high for exactly one cycle per input beat, with
// o_vertex_index, o_is_new and o_overflow alongside. Results come out in the
// order the tuples were taken. The receiver cannot stall; it must take every
// result in the cycle it is shown.
// Search: the search engine reads the tuple table through one port, one entry
// per cycle, in storage order, and stops at the first matching entry, so a
// search ends sooner when a match is found early. The engine works on one
// tuple at a time and pops the next one from the queue only once it has
// finished the last; beats taken meanwhile wait in the queue.
// Reset: a synchronous active-low reset empties the queue and sets the table
// count to zero; table contents are not cleared and need no clearing pass.
// The count also returns to zero after any tuple flagged as last in its mesh.
module vertex_tuple_dedup_indexer_top
    import vtdi_pkg::*;
#(
    parameter int MAX_UNIQUE = 1024,
    parameter int INDEX_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [IN_BITS-1:0] i_position_index,
    input  logic signed [IN_BITS-1:0] i_normal_index,
    input  logic signed [IN_BITS-1:0] i_texcoord_index,
    input  logic signed [IN_BITS-1:0] i_tangent_index,
    input  logic signed [IN_BITS-1:0] i_binormal_index,
    input  logic                      i_last_in_mesh,
    output logic                      o_valid,
    output logic [OUT_BITS-1:0]       o_vertex_index,
    output logic                      o_is_new,
    output logic                      o_overflow
);

    localparam int DATA_BITS = FIELD_COUNT * INDEX_BITS + 1;

    t_q_status            q_status;
    logic                 q_push;
    logic [DATA_BITS-1:0] q_push_data;
    logic                 q_pop;
    logic [DATA_BITS-1:0] q_head_data;

    // Front: accepts beats and narrows the source indices.
    vtdi_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_start          (start),
        .i_position_index (i_position_index),
        .i_normal_index   (i_normal_index),
        .i_texcoord_index (i_texcoord_index),
        .i_tangent_index  (i_tangent_index),
        .i_binormal_index (i_binormal_index),
        .i_last_in_mesh   (i_last_in_mesh),
        .i_q_status       (q_status),
        .o_busy           (busy),
        .o_push           (q_push),
        .o_push_data      (q_push_data)
    );

    // Queue between the front and the search engine.
    vtdi_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head_data (q_head_data),
        .o_status    (q_status)
    );

    // Back: table search, insertion and result registers.
    vtdi_back #(
        .MAX_UNIQUE (MAX_UNIQUE),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_head_data    (q_head_data),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_overflow     (o_overflow)
    );

endmodule
